// ----- sv/aeg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aeg_pkg;

  // Widths of the position and of the level fraction
  localparam int LENGTH_BITS         = 24;
  localparam int LEVEL_FRACTION_BITS = 15;

  localparam int LEVEL_W   = LEVEL_FRACTION_BITS + 1;
  localparam int PROD_W    = LEVEL_W + LENGTH_BITS;
  localparam int DIV_CNT_W = $clog2(LEVEL_FRACTION_BITS);
  localparam int ACTION_W  = 2;
  localparam int ADVANCE_W = 16;
  localparam int SUSTAIN_W = 16;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [LEVEL_W-1:0]     FULL_SCALE = LEVEL_W'(1) << LEVEL_FRACTION_BITS;
  localparam logic [LENGTH_BITS-1:0] POS_MAX    = {LENGTH_BITS{1'b1}};
  localparam logic [DIV_CNT_W-1:0]   DIV_LAST   = DIV_CNT_W'(LEVEL_FRACTION_BITS - 1);

  // Reset values of the configuration registers
  localparam logic [LENGTH_BITS-1:0] LENGTH_RESET  = LENGTH_BITS'(14400);
  localparam logic [SUSTAIN_W-1:0]   SUSTAIN_RESET = SUSTAIN_W'(26214);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = CFG_IDX_W'(4);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_NOTE_ON  = 2'd1,
    ACT_NOTE_OFF = 2'd2
  } action_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_HOLD    = 3'd2,
    PH_DECAY   = 3'd3,
    PH_SUSTAIN = 3'd4,
    PH_RELEASE = 3'd5
  } phase_e;

  // Top level sequencer
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_RAMP = 2'd2,
    ST_EMIT = 2'd3
  } seq_state_e;

  // Ramp unit sequencer
  typedef enum logic [1:0] {
    RS_IDLE = 2'd0,
    RS_LOAD = 2'd1,
    RS_DIV  = 2'd2,
    RS_DONE = 2'd3
  } ramp_state_e;

  typedef struct packed {
    logic                   start;
    logic [LEVEL_W-1:0]     span;
    logic [LENGTH_BITS-1:0] pos;
    logic [LENGTH_BITS-1:0] len;
  } ramp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ramp_stat_t;

endpackage

`default_nettype wire

// ----- sv/ahdsr_envelope_generator_unit.sv -----
// Linear attack-hold-decay-sustain-release envelope. A request carries an action: note on
// restarts attack, note off enters release (unless idle); both keep the request side ready
// and give no result. A tick adds its sample count to the saturating phase position, walks
// past every phase whose length is reached (one phase per cycle, at most three), and then
// returns the level (unsigned Q1.15) and the phase. Ramp phases go through one shared
// multiply and a restoring divider that retires one quotient bit a cycle. After a tick is
// taken the request side stays busy through the phase walk, the ramp when it ends in
// attack, decay or release, and the emit step. One request is worked on at a time; a
// result waits in the output register while the next request is taken, and the emit step
// stalls while that earlier result is still waiting. Configuration is written through a
// plain write port; the user must write it while no work runs, the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module ahdsr_envelope_generator_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [aeg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [aeg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [aeg_pkg::ACTION_W-1:0]       action_i,
  input  wire logic [aeg_pkg::ADVANCE_W-1:0]      advance_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [aeg_pkg::LEVEL_W-1:0]             level_o,
  output logic [aeg_pkg::PHASE_W-1:0]             phase_o
);
  import aeg_pkg::*;

  // Configuration registers
  logic [LENGTH_BITS-1:0] attack_q, hold_q, decay_q, release_q;
  logic [SUSTAIN_W-1:0]   sustain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= LENGTH_RESET;
      hold_q    <= LENGTH_RESET;
      decay_q   <= LENGTH_RESET;
      sustain_q <= SUSTAIN_RESET;
      release_q <= LENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ATTACK:  attack_q  <= cfg_data_i[LENGTH_BITS-1:0];
        REG_HOLD:    hold_q    <= cfg_data_i[LENGTH_BITS-1:0];
        REG_DECAY:   decay_q   <= cfg_data_i[LENGTH_BITS-1:0];
        REG_SUSTAIN: sustain_q <= cfg_data_i[SUSTAIN_W-1:0];
        REG_RELEASE: release_q <= cfg_data_i[LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sustain clamped to full scale
  logic [LEVEL_W-1:0] sus_lvl;
  assign sus_lvl = (sustain_q > SUSTAIN_W'(FULL_SCALE)) ? FULL_SCALE
                                                        : sustain_q[LEVEL_W-1:0];

  seq_state_e             state_q, state_d;
  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [LEVEL_W-1:0]     level_q, level_d;
  logic                   out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]     out_level_q, out_level_d;
  phase_e                 out_phase_q, out_phase_d;

  ramp_req_t                      ramp_req;
  ramp_stat_t                     ramp_stat;
  logic [LEVEL_FRACTION_BITS-1:0] ramp_quot;

  logic                   accept;
  logic [LENGTH_BITS:0]   pos_sum;
  logic                   walk_move;
  phase_e                 walk_next;
  logic                   is_ramp;
  logic                   emit_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign pos_sum    = (LENGTH_BITS + 1)'(pos_q) + (LENGTH_BITS + 1)'(advance_i);
  assign emit_ok    = !out_valid_q || out_ready_i;

  // Phase walk: leave the current phase once its length is reached
  always_comb begin
    walk_move = 1'b0;
    walk_next = phase_q;
    case (phase_q)
      PH_ATTACK: begin
        walk_move = (pos_q >= attack_q);
        walk_next = PH_HOLD;
      end
      PH_HOLD: begin
        walk_move = (pos_q >= hold_q);
        walk_next = PH_DECAY;
      end
      PH_DECAY: begin
        walk_move = (pos_q >= decay_q);
        walk_next = PH_SUSTAIN;
      end
      PH_RELEASE: begin
        walk_move = (pos_q >= release_q);
        walk_next = PH_IDLE;
      end
      default: ;
    endcase
  end

  // Pick span and length of the ramp for the current phase
  always_comb begin
    is_ramp       = 1'b0;
    ramp_req.span = '0;
    ramp_req.len  = '0;
    ramp_req.pos  = pos_q;
    case (phase_q)
      PH_ATTACK: begin
        is_ramp       = 1'b1;
        ramp_req.span = FULL_SCALE;
        ramp_req.len  = attack_q;
      end
      PH_DECAY: begin
        is_ramp       = 1'b1;
        ramp_req.span = FULL_SCALE - sus_lvl;
        ramp_req.len  = decay_q;
      end
      PH_RELEASE: begin
        is_ramp       = 1'b1;
        ramp_req.span = sus_lvl;
        ramp_req.len  = release_q;
      end
      default: ;
    endcase
    ramp_req.start = (state_q == ST_WALK) && !walk_move && is_ramp;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (action_e'(action_i) == ACT_TICK)) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!walk_move) state_d = is_ramp ? ST_RAMP : ST_EMIT;
      end
      ST_RAMP: if (ramp_stat.done) state_d = ST_EMIT;
      ST_EMIT: if (emit_ok) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    level_d     = level_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_level_d = out_level_q;
    out_phase_d = out_phase_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_TICK: pos_d = pos_sum[LENGTH_BITS] ? POS_MAX : pos_sum[LENGTH_BITS-1:0];
            ACT_NOTE_ON: begin
              pos_d   = '0;
              phase_d = PH_ATTACK;
            end
            ACT_NOTE_OFF: begin
              pos_d = '0;
              if (phase_q != PH_IDLE) phase_d = PH_RELEASE;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_move) begin
          phase_d = walk_next;
          pos_d   = '0;
        end else begin
          case (phase_q)
            PH_HOLD:    level_d = FULL_SCALE;
            PH_SUSTAIN: level_d = sus_lvl;
            default:    level_d = '0;
          endcase
        end
      end
      ST_RAMP: begin
        if (ramp_stat.done) begin
          case (phase_q)
            PH_ATTACK:  level_d = LEVEL_W'(ramp_quot);
            PH_DECAY:   level_d = FULL_SCALE - LEVEL_W'(ramp_quot);
            PH_RELEASE: level_d = sus_lvl - LEVEL_W'(ramp_quot);
            default:    level_d = '0;
          endcase
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          out_level_d = level_q;
          out_phase_d = phase_q;
        end
      end
      default: ;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    level_q     <= level_d;
    out_level_q <= out_level_d;
    out_phase_q <= out_phase_d;
  end

  aeg_ramp_unit u_ramp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ramp_req),
    .stat_o (ramp_stat),
    .quot_o (ramp_quot)
  );

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign phase_o     = out_phase_q;

`ifndef NO_ASSERTIONS
  // No request is taken while the ramp unit works
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_stat.busy |-> !in_ready_o)
    else $error("request taken while ramp unit busy");

  // Ramp completion only while the sequencer waits for it
  a_done_in_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_stat.done |-> (state_q == ST_RAMP))
    else $error("ramp done outside ramp state");

  // A result appears only after the emit step
  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EMIT))
    else $error("result raised without emit");

  // The level never exceeds full scale
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_o <= FULL_SCALE))
    else $error("level above full scale");
`endif

endmodule

`default_nettype wire

// ----- sv/aeg_ramp_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ramp unit: span * pos / len, one multiply then a restoring divide one bit a cycle.
// The caller keeps pos below len, so the quotient fits in the fraction bits.
module aeg_ramp_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire aeg_pkg::ramp_req_t                    req_i,
  output aeg_pkg::ramp_stat_t                        stat_o,
  output logic [aeg_pkg::LEVEL_FRACTION_BITS-1:0]    quot_o
);
  import aeg_pkg::*;

  ramp_state_e                    state_q, state_d;
  logic [PROD_W-1:0]              product_q, product_d;
  logic [LENGTH_BITS-1:0]         len_q, len_d;
  logic [LENGTH_BITS-1:0]         rem_q, rem_d;
  logic [LEVEL_FRACTION_BITS-1:0] low_q, low_d;
  logic [DIV_CNT_W-1:0]           cnt_q, cnt_d;

  logic [LENGTH_BITS:0] shifted;
  logic [LENGTH_BITS:0] diff;
  logic                 ge;

  // One restoring division step
  always_comb begin
    shifted = {rem_q, low_q[LEVEL_FRACTION_BITS-1]};
    diff    = shifted - {1'b0, len_q};
    ge      = (shifted >= {1'b0, len_q});
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      RS_IDLE: if (req_i.start) state_d = RS_LOAD;
      RS_LOAD: state_d = RS_DIV;
      RS_DIV:  if (cnt_q == DIV_LAST) state_d = RS_DONE;
      RS_DONE: state_d = RS_IDLE;
      default: state_d = RS_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    product_d = product_q;
    len_d     = len_q;
    rem_d     = rem_q;
    low_d     = low_q;
    cnt_d     = cnt_q;
    case (state_q)
      RS_IDLE: begin
        if (req_i.start) begin
          product_d = PROD_W'(req_i.span) * PROD_W'(req_i.pos);
          len_d     = req_i.len;
        end
      end
      RS_LOAD: begin
        rem_d = product_q[LEVEL_FRACTION_BITS +: LENGTH_BITS];
        low_d = product_q[LEVEL_FRACTION_BITS-1:0];
        cnt_d = '0;
      end
      RS_DIV: begin
        rem_d = ge ? diff[LENGTH_BITS-1:0] : shifted[LENGTH_BITS-1:0];
        low_d = {low_q[LEVEL_FRACTION_BITS-2:0], ge};
        cnt_d = cnt_q + DIV_CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold the operands
  always_ff @(posedge clk_i) begin
    product_q <= product_d;
    len_q     <= len_d;
    rem_q     <= rem_d;
    low_q     <= low_d;
  end

  assign stat_o.busy = (state_q != RS_IDLE);
  assign stat_o.done = (state_q == RS_DONE);
  assign quot_o      = low_q;

endmodule

`default_nettype wire

// ----- tb/sv/ahdsr_envelope_checker.sv -----
`timescale 1ns / 1ps

module ahdsr_envelope_checker
  import aeg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [ACTION_W-1:0]    action_i,
  input  logic [ADVANCE_W-1:0]   advance_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [LEVEL_W-1:0]     level_i,
  input  logic [PHASE_W-1:0]     phase_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o,
  output int unsigned            levels_checked_o,
  output logic [5:0]             phases_seen_o
);

  localparam int unsigned PRINT_LIMIT = 100;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    phase_e             phase;
  } env_point_t;

  // Levels still owed by the block, oldest first
  env_point_t points_due[$];
  env_point_t got_point;

  // Shadow of the configuration registers
  logic [LENGTH_BITS-1:0] attack_len;
  logic [LENGTH_BITS-1:0] hold_len;
  logic [LENGTH_BITS-1:0] decay_len;
  logic [LENGTH_BITS-1:0] release_len;
  logic [SUSTAIN_W-1:0]   sustain_cfg;

  // Envelope state as the block should hold it
  phase_e                 env_phase;
  logic [LENGTH_BITS-1:0] env_pos;

  int unsigned mismatches  = 0;
  int unsigned due_count   = 0;
  int unsigned levels_seen = 0;
  logic [5:0]  phases_hit  = '0;

  assign fail_count_o     = mismatches;
  assign pending_o        = due_count;
  assign levels_checked_o = levels_seen;
  assign phases_seen_o    = phases_hit;

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  // Truncated share of a span over a ramp; an empty ramp counts as finished
  function automatic logic [LEVEL_W-1:0] ramp_share(input logic [LEVEL_W-1:0] span,
                                                    input logic [LENGTH_BITS-1:0] p,
                                                    input logic [LENGTH_BITS-1:0] len);
    logic [63:0] prod;
    if (len == '0) return span;
    prod = 64'(span) * 64'(p);
    return LEVEL_W'(prod / 64'(len));
  endfunction

  // Advance the envelope by one request and queue the level a tick owes
  task automatic step_envelope(input logic [ACTION_W-1:0] act,
                               input logic [ADVANCE_W-1:0] adv);
    logic [LENGTH_BITS:0] sum;
    logic [LEVEL_W-1:0]   sus;
    env_point_t           pt;
    bit                   walking;
    sus = (sustain_cfg > FULL_SCALE) ? FULL_SCALE : sustain_cfg;
    case (act)
      ACT_NOTE_ON: begin
        env_pos   = '0;
        env_phase = PH_ATTACK;
      end
      ACT_NOTE_OFF: begin
        env_pos = '0;
        if (env_phase != PH_IDLE) env_phase = PH_RELEASE;
      end
      ACT_TICK: begin
        // saturate the position, then skip every phase whose length is reached
        sum     = env_pos + adv;
        env_pos = sum[LENGTH_BITS] ? POS_MAX : sum[LENGTH_BITS-1:0];
        walking = 1'b1;
        while (walking) begin
          walking = 1'b0;
          case (env_phase)
            PH_ATTACK: if (env_pos >= attack_len) begin
              env_phase = PH_HOLD;
              env_pos   = '0;
              walking   = 1'b1;
            end
            PH_HOLD: if (env_pos >= hold_len) begin
              env_phase = PH_DECAY;
              env_pos   = '0;
              walking   = 1'b1;
            end
            PH_DECAY: if (env_pos >= decay_len) begin
              env_phase = PH_SUSTAIN;
              env_pos   = '0;
              walking   = 1'b1;
            end
            PH_RELEASE: if (env_pos >= release_len) begin
              env_phase = PH_IDLE;
              env_pos   = '0;
            end
            default: ;
          endcase
        end
        pt.phase = env_phase;
        case (env_phase)
          PH_ATTACK:  pt.level = ramp_share(FULL_SCALE, env_pos, attack_len);
          PH_HOLD:    pt.level = FULL_SCALE;
          PH_DECAY:   pt.level = FULL_SCALE - ramp_share(FULL_SCALE - sus, env_pos, decay_len);
          PH_SUSTAIN: pt.level = sus;
          PH_RELEASE: pt.level = sus - ramp_share(sus, env_pos, release_len);
          default:    pt.level = '0;
        endcase
        points_due.push_back(pt);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len  = LENGTH_RESET;
      hold_len    = LENGTH_RESET;
      decay_len   = LENGTH_RESET;
      release_len = LENGTH_RESET;
      sustain_cfg = SUSTAIN_RESET;
      env_phase   = PH_IDLE;
      env_pos     = '0;
      points_due.delete();
      due_count   = 0;
    end else begin
      // compare a returned level with the oldest one owed
      if (out_valid_i && out_ready_i) begin
        if (points_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result level %0d phase %0d", level_i, phase_i));
        end else begin
          got_point = points_due.pop_front();
          levels_seen++;
          if (level_i !== got_point.level)
            flag_mismatch($sformatf("level %0d, expected %0d (phase %0d)",
                                    level_i, got_point.level, got_point.phase));
          if (phase_i !== got_point.phase)
            flag_mismatch($sformatf("phase %0d, expected %0d", phase_i, got_point.phase));
        end
        if (phase_i <= PH_RELEASE) phases_hit[phase_i] = 1'b1;
      end
      // mirror register writes; unused indexes fall through
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ATTACK:  attack_len  = cfg_data_i[LENGTH_BITS-1:0];
          REG_HOLD:    hold_len    = cfg_data_i[LENGTH_BITS-1:0];
          REG_DECAY:   decay_len   = cfg_data_i[LENGTH_BITS-1:0];
          REG_SUSTAIN: sustain_cfg = cfg_data_i[SUSTAIN_W-1:0];
          REG_RELEASE: release_len = cfg_data_i[LENGTH_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) step_envelope(action_i, advance_i);
      due_count = points_due.size();
    end
  end

endmodule

// ----- tb/sv/ahdsr_envelope_generator_unit_tb.sv -----
`timescale 1ns / 1ps

module ahdsr_envelope_generator_unit_tb;
  import aeg_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int RESET_CYCLES      = 12;
  localparam int SETTLE_CYCLES     = 40;
  localparam int LONG_HOLD_CYCLES  = 300;
  localparam int SETTING_COUNT     = 8;
  localparam int ITEMS_PER_SETTING = 180;
  localparam int TIMEOUT_NS        = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  req_valid;
  logic                  req_ready;
  logic [ACTION_W-1:0]   req_action;
  logic [ADVANCE_W-1:0]  req_advance;
  logic                  res_valid;
  logic                  res_ready;
  logic [LEVEL_W-1:0]    res_level;
  logic [PHASE_W-1:0]    res_phase;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned levels_checked;
  logic [5:0]  phases_seen;

  bit          quiet;
  bit          long_hold_go;
  int unsigned requests_sent;
  int unsigned ticks_sent;
  int unsigned setting_items;
  int unsigned settings_applied;

  ahdsr_envelope_generator_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .action_i    (req_action),
    .advance_i   (req_advance),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .level_o     (res_level),
    .phase_o     (res_phase)
  );

  ahdsr_envelope_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (req_valid),
    .in_ready_i       (req_ready),
    .action_i         (req_action),
    .advance_i        (req_advance),
    .out_valid_i      (res_valid),
    .out_ready_i      (res_ready),
    .level_i          (res_level),
    .phase_i          (res_phase),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .levels_checked_o (levels_checked),
    .phases_seen_o    (phases_seen)
  );

  always #1 clk = ~clk;

  // Offer one request from a falling edge and hold it until taken
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [ADVANCE_W-1:0] adv);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_valid   <= 1'b1;
    req_action  <= act;
    req_advance <= adv;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
    if (act == ACT_TICK) ticks_sent++;
    if (act != ACT_UNUSED) setting_items++;
  endtask

  function automatic logic [ADVANCE_W-1:0] pick_advance(input int unsigned adv_max);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return ADVANCE_W'($urandom);
      default: return ADVANCE_W'($urandom_range(0, adv_max));
    endcase
  endfunction

  function automatic logic [LENGTH_BITS-1:0] pick_length(input int unsigned top);
    if ($urandom_range(0, 3) == 0) return '0;
    return LENGTH_BITS'($urandom_range(1, top));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Drain the block, then load a full register set plus a stray write
  task automatic apply_setting(input logic [LENGTH_BITS-1:0] a, input logic [LENGTH_BITS-1:0] h,
                               input logic [LENGTH_BITS-1:0] d, input logic [SUSTAIN_W-1:0] s,
                               input logic [LENGTH_BITS-1:0] r);
    // withdraw the last request so it is not taken again
    req_valid <= 1'b0;
    wait (pending == 0 && !long_hold_go);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_ATTACK, a);
    write_reg(REG_HOLD, h);
    write_reg(REG_DECAY, d);
    write_reg(REG_SUSTAIN, {8'($urandom), s});
    write_reg(REG_RELEASE, r);
    write_reg(REG_RELEASE + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Note on, a run of ticks, usually a note off, then ticks through release
  task automatic play_note(input int unsigned adv_max);
    int unsigned n_on;
    int unsigned n_off;
    n_on  = $urandom_range(1, 24);
    n_off = $urandom_range(0, 16);
    send_request(ACT_NOTE_ON, ADVANCE_W'($urandom));
    repeat (n_on) send_request(ACT_TICK, pick_advance(adv_max));
    if ($urandom_range(0, 9) != 0) send_request(ACT_NOTE_OFF, ADVANCE_W'($urandom));
    repeat (n_off) send_request(ACT_TICK, pick_advance(adv_max));
  endtask

  // Result side: short random stalls, and one long hold-off on request
  initial begin : result_sink
    res_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_go) begin
        res_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        res_ready <= 1'b1;
        long_hold_go = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned adv_max;
    bit          hold_done;
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    req_valid        = 1'b0;
    req_action       = ACT_TICK;
    req_advance      = '0;
    quiet            = 1'b0;
    long_hold_go     = 1'b0;
    hold_done        = 1'b0;
    adv_max          = 0;
    requests_sent    = 0;
    ticks_sent       = 0;
    setting_items    = 0;
    settings_applied = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the reset setting through every phase and the odd cases
    send_request(ACT_TICK, '0);
    send_request(ACT_NOTE_OFF, '1);
    send_request(ACT_TICK, '1);
    send_request(ACT_UNUSED, '1);
    send_request(ACT_NOTE_ON, '0);
    send_request(ACT_TICK, '0);
    send_request(ACT_TICK, 16'd1);
    send_request(ACT_TICK, 16'd7200);
    send_request(ACT_TICK, '1);
    send_request(ACT_TICK, 16'd14400);
    send_request(ACT_TICK, 16'd7200);
    send_request(ACT_TICK, 16'd20000);
    send_request(ACT_UNUSED, '0);
    send_request(ACT_TICK, 16'd5);
    send_request(ACT_NOTE_OFF, '0);
    send_request(ACT_TICK, 16'd3600);
    send_request(ACT_NOTE_ON, '0);
    send_request(ACT_TICK, 16'd100);
    send_request(ACT_NOTE_OFF, '0);
    send_request(ACT_TICK, 16'd14399);
    send_request(ACT_TICK, 16'd1);
    send_request(ACT_TICK, '0);
    send_request(ACT_NOTE_OFF, '0);

    // Random phases, each under its own register setting
    for (int k = 0; k < SETTING_COUNT; k++) begin
      case (k)
        0: begin
          apply_setting('0, '0, '0, '0, '0);
          adv_max = 16;
        end
        1: begin
          apply_setting(LENGTH_BITS'($urandom_range(1, 8)), LENGTH_BITS'($urandom_range(1, 8)),
                        LENGTH_BITS'($urandom_range(1, 8)),
                        SUSTAIN_W'($urandom_range(0, 32768)), LENGTH_BITS'($urandom_range(1, 8)));
          adv_max = 12;
        end
        2: begin
          apply_setting(pick_length(2000), pick_length(2000), pick_length(2000),
                        SUSTAIN_W'($urandom_range(0, 32768)), pick_length(2000));
          adv_max = 600;
        end
        3: begin
          apply_setting(POS_MAX, POS_MAX, POS_MAX, FULL_SCALE, POS_MAX);
          adv_max = 65535;
        end
        4: begin
          apply_setting(pick_length(300), pick_length(300), pick_length(300),
                        SUSTAIN_W'($urandom_range(32769, 65535)), pick_length(300));
          adv_max = 200;
        end
        5: begin
          apply_setting(pick_length(1000), pick_length(1000), pick_length(1000),
                        SUSTAIN_W'($urandom_range(0, 32768)), pick_length(1000));
          adv_max = 400;
        end
        6: begin
          apply_setting(LENGTH_BITS'($urandom >> $urandom_range(8, 31)),
                        LENGTH_BITS'($urandom >> $urandom_range(8, 31)),
                        LENGTH_BITS'($urandom >> $urandom_range(8, 31)),
                        SUSTAIN_W'($urandom),
                        LENGTH_BITS'($urandom >> $urandom_range(8, 31)));
          adv_max = 65535;
        end
        default: begin
          apply_setting(pick_length(1000), pick_length(1000), pick_length(1000),
                        SUSTAIN_W'($urandom_range(0, 32768)), pick_length(1000));
          adv_max = 500;
        end
      endcase
      // drop all idling for the closing phase
      quiet = (k == SETTING_COUNT - 1);
      setting_items = 0;
      while (setting_items < ITEMS_PER_SETTING) begin
        if (k == 2 && !hold_done && setting_items >= 60) begin
          long_hold_go = 1'b1;
          hold_done    = 1'b1;
        end
        if ($urandom_range(0, 9) < 8) begin
          play_note(adv_max);
        end else begin
          send_request(ACTION_W'($urandom_range(0, 3)), ADVANCE_W'($urandom));
        end
      end
    end
    req_valid <= 1'b0;

    // Drain, then give the block time to show any stray result
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Summary: %0d requests (%0d ticks) across the reset values and %0d settings",
             requests_sent, ticks_sent, settings_applied);
    $display("Summary: %0d levels compared, phases returned (idle is bit 0) %06b",
             levels_checked, phases_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
